### src/greedy_load_balance_assigner_top_defines.svh
// assertion macros for the load balance assigner
`ifndef GREEDY_LOAD_BALANCE_ASSIGNER_TOP_DEFINES_SVH
`define GREEDY_LOAD_BALANCE_ASSIGNER_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define GLB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// consequence due at the clock edge after the antecedent
`define GLB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// condition that holds on every clock edge outside reset
`define GLB_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

### src/glba_pkg.sv
// shared constants and types for the load balance assigner
package glba_pkg;
   localparam int MAX_JOBS   = 64;
   localparam int MAX_NODES  = 16;
   localparam int JOB_W      = 10;
   localparam int IDX_W      = $clog2(MAX_JOBS);
   localparam int CNT_W      = $clog2(MAX_JOBS + 1);
   localparam int NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int NCNT_W     = $clog2(MAX_NODES + 1);
   localparam int LOAD_W     = 16;
   localparam int CFG_NODE_W = 5;
   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

   typedef struct packed {
      logic clear;
      logic load_job;
      logic sort_init;
      logic sort_outer;
      logic sort_step;
      logic sort_place;
      logic prev_rd;
      logic asg_init;
      logic scan_step;
      logic rd_issue;
      logic commit;
      logic done;
   } glba_cmd_type;

   typedef struct packed {
      logic sort_cmp_move;
      logic sort_j_zero;
      logic sort_i_end;
      logic scan_end;
      logic asg_end;
      logic full;
   } glba_sts_type;
endpackage

### src/glba_ctrl.sv
// controller state machine: load, sort, assign
module glba_ctrl
   import glba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tlast,
   output logic         req_tready,
   input  logic         out_busy,
   input  glba_sts_type sts,
   output glba_cmd_type cmd
);
   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_SORTI = 3'd1;
   localparam logic [2:0] ST_SORTR = 3'd2;
   localparam logic [2:0] ST_SORTC = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_RD    = 3'd5;
   localparam logic [2:0] ST_CMT   = 3'd6;
   localparam logic [2:0] ST_SORTW = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       acc;

   assign req_tready = (state_ff == ST_LOAD);
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            cmd.load_job = acc;
            if (acc && req_tlast) begin
               cmd.sort_init = 1'b1;
               state_in      = ST_SORTI;
            end
         end
         ST_SORTI: begin
            if (sts.sort_i_end) begin
               cmd.asg_init = 1'b1;
               state_in     = ST_SCAN;
            end else begin
               cmd.sort_outer = 1'b1;
               state_in       = ST_SORTR;
            end
         end
         ST_SORTR: begin
            // read sorted_order[j-1]
            if (sts.sort_j_zero) begin
               cmd.sort_place = 1'b1;
               state_in       = ST_SORTI;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_SORTW;
            end
         end
         ST_SORTW: begin
            // then the weight of that job
            cmd.prev_rd = 1'b1;
            state_in    = ST_SORTC;
         end
         ST_SORTC: begin
            if (sts.sort_cmp_move) begin
               cmd.sort_step = 1'b1;
               state_in      = ST_SORTR;
            end else begin
               cmd.sort_place = 1'b1;
               state_in       = ST_SORTI;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_end) state_in = ST_RD;
         end
         ST_RD: begin
            if (!out_busy) begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_CMT;
            end
         end
         ST_CMT: begin
            cmd.commit = 1'b1;
            if (sts.asg_end) begin
               cmd.done = 1'b1;
               state_in = ST_LOAD;
            end else begin
               cmd.asg_init = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end
endmodule

### src/glba_dpath.sv
// datapath: job store, insertion sort, node load scan and output register
module glba_dpath
   import glba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  glba_cmd_type          cmd,
   output glba_sts_type          sts,
   input  logic [JOB_W-1:0]      req_weight,
   input  logic [CFG_NODE_W-1:0] node_count,
   output logic                  out_busy,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [IDX_W-1:0]      rsp_index,
   output logic [NODE_W-1:0]     rsp_node,
   output logic [LOAD_W-1:0]     rsp_load,
   output logic                  rsp_last
);
   `include "greedy_load_balance_assigner_top_defines.svh"

   logic [JOB_W-1:0]  wmem [MAX_JOBS];
   logic [IDX_W-1:0]  omem [MAX_JOBS];
   logic [LOAD_W-1:0] loads_ff [MAX_NODES];

   logic [CNT_W-1:0]  held_ff, held_in;
   logic [CNT_W-1:0]  i_ff, j_ff, k_ff;
   logic [JOB_W-1:0]  key_w_ff;
   logic [IDX_W-1:0]  prev_idx_ff;   // sorted_order[j-1] read
   logic [JOB_W-1:0]  prev_w_ff;
   logic [IDX_W-1:0]  w_addr;
   logic [IDX_W-1:0]  cur_idx_ff;
   logic [JOB_W-1:0]  cur_w_ff;
   logic [NCNT_W-1:0] nodes;
   logic [NCNT_W-1:0] scan_ff;
   logic [NODE_W-1:0] best_ff;
   logic [LOAD_W:0]   sum;
   logic              vld_ff;
   logic [IDX_W-1:0]  o_idx_ff;
   logic [NODE_W-1:0] o_node_ff;
   logic [LOAD_W-1:0] o_load_ff;
   logic              o_last_ff;

   always_comb begin
      if (node_count == '0) nodes = NCNT_W'(1);
      else if (node_count > CFG_NODE_W'(MAX_NODES)) nodes = NCNT_W'(MAX_NODES);
      else nodes = NCNT_W'(node_count);
   end

   // single read port of the weight store
   always_comb begin
      if (cmd.sort_outer)   w_addr = i_ff[IDX_W-1:0];
      else if (cmd.prev_rd) w_addr = prev_idx_ff;
      else                  w_addr = cur_idx_ff;
   end

   assign sts.full          = (held_ff == CNT_W'(MAX_JOBS));
   assign sts.sort_i_end    = (i_ff == held_ff);
   assign sts.sort_j_zero   = (j_ff == '0);
   assign sts.sort_cmp_move = (prev_w_ff < key_w_ff);
   assign sts.scan_end      = (scan_ff >= nodes - NCNT_W'(1));
   assign sts.asg_end       = (k_ff + CNT_W'(1) == held_ff);
   assign out_busy          = vld_ff && !rsp_tready;

   assign sum = {1'b0, loads_ff[best_ff]} + (LOAD_W+1)'(cur_w_ff);

   always_comb begin
      held_in = held_ff;
      if (cmd.done) held_in = '0;
      else if (cmd.load_job && !sts.full) held_in = held_ff + CNT_W'(1);
   end

   // job weight store
   always_ff @(posedge clock) begin
      if (cmd.load_job && !sts.full) wmem[held_ff[IDX_W-1:0]] <= req_weight;
   end

   always_ff @(posedge clock) begin
      if (cmd.sort_outer) key_w_ff <= wmem[w_addr];
      if (cmd.prev_rd) prev_w_ff <= wmem[w_addr];
      if (cmd.rd_issue) cur_w_ff <= wmem[w_addr];
   end

   // sorted order store: shift on move, key on place
   always_ff @(posedge clock) begin
      if (cmd.sort_step) omem[j_ff[IDX_W-1:0]] <= prev_idx_ff;
      else if (cmd.sort_place) omem[j_ff[IDX_W-1:0]] <= i_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         if (cmd.commit == 1'b0 && j_ff != '0 && cmd.asg_init == 1'b0)
            prev_idx_ff <= omem[j_ff[IDX_W-1:0] - IDX_W'(1)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         vld_ff  <= 1'b0;
      end else begin
         held_ff <= held_in;
         if (cmd.commit) vld_ff <= 1'b1;
         else if (rsp_tready) vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sort_init) begin
         i_ff <= '0;
         k_ff <= '0;
         for (int n = 0; n < MAX_NODES; n++) loads_ff[n] <= '0;
      end
      if (cmd.sort_outer) j_ff <= i_ff;
      if (cmd.sort_step) j_ff <= j_ff - CNT_W'(1);
      if (cmd.sort_place) i_ff <= i_ff + CNT_W'(1);
      if (cmd.asg_init) begin
         scan_ff <= NCNT_W'(1);
         best_ff <= '0;
         // k moves on at the same edge when a commit comes with it
         cur_idx_ff <= cmd.commit ? omem[k_ff[IDX_W-1:0] + IDX_W'(1)]
                                  : omem[k_ff[IDX_W-1:0]];
      end
      if (cmd.scan_step && scan_ff < nodes) begin
         if (loads_ff[scan_ff[NODE_W-1:0]] < loads_ff[best_ff])
            best_ff <= scan_ff[NODE_W-1:0];
         scan_ff <= scan_ff + NCNT_W'(1);
      end
      if (cmd.commit) begin
         loads_ff[best_ff] <= sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
         o_idx_ff  <= cur_idx_ff;
         o_node_ff <= best_ff;
         o_load_ff <= sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
         o_last_ff <= sts.asg_end;
         k_ff      <= k_ff + CNT_W'(1);
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_index  = o_idx_ff;
   assign rsp_node   = o_node_ff;
   assign rsp_load   = o_load_ff;
   assign rsp_last   = o_last_ff;

   `GLB_ASSERT_ALWAYS(a_held_max, clock, reset, held_ff <= CNT_W'(MAX_JOBS), "job count overflow")
   `GLB_ASSERT_IMPL(a_commit_free, clock, reset, cmd.commit, !out_busy, "result overwritten")
   `GLB_ASSERT_NEXT(a_done_clear, clock, reset, cmd.done, held_ff == '0, "set not closed")
endmodule

### src/greedy_load_balance_assigner_top.sv
// n jobs load at one per cycle; after the last job the insertion sort starts
// each job, reads and compares for each compare step, and places the job
// each job is then assigned by a scan over the node loads, a read and a commit,
// the read waiting while the output register holds an untaken result
// input is refused from the last job until the last result enters the output register
// reset is synchronous: job count, state and node_count (1) are cleared, stores are not
module greedy_load_balance_assigner_top
   import glba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // job_weight
   input  logic        req_tlast,   // last_job
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // job_index, assigned_node, node_load_after
   output logic        rsp_tlast,   // last_result
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   glba_cmd_type          cmd;
   glba_sts_type          sts;
   logic                  out_busy;
   logic [CFG_NODE_W-1:0] node_count_ff;
   logic [IDX_W-1:0]      o_idx;
   logic [NODE_W-1:0]     o_node;
   logic [LOAD_W-1:0]     o_load;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {{(32-CFG_NODE_W){1'b0}}, node_count_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) node_count_ff <= CFG_NODE_W'(1);
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         node_count_ff <= csr_pwdata[CFG_NODE_W-1:0];
   end

   glba_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tlast, .req_tready,
      .out_busy, .sts, .cmd
   );

   glba_dpath u_dpath (
      .clock, .reset, .cmd, .sts,
      .req_weight (req_tdata[JOB_W-1:0]),
      .node_count (node_count_ff),
      .out_busy, .rsp_tvalid, .rsp_tready,
      .rsp_index (o_idx), .rsp_node (o_node), .rsp_load (o_load),
      .rsp_last (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, o_load, o_node, o_idx};
endmodule

### tb/greedy_load_balance_assigner_top_test.sv
// testbench for the greedy load balance assigner: stimulus, prediction and checks
`timescale 1ns / 100ps

class assignment_scoreboard;
   logic [9:0]  weights[$];
   int          nodes;
   int          pending_jobs[$];
   int          pending_nodes[$];
   int          pending_loads[$];
   bit          pending_last[$];
   int          errors;

   function new();
      nodes = 1;
      errors = 0;
   endfunction

   function void set_nodes(int value);
      nodes = value & 31;
   endfunction

   // note an accepted job; on the last job the whole set is scheduled
   function void note_job(logic [9:0] weight, bit last);
      int order[$];
      int loads[16];
      int count, n, pos, best, load;
      if (weights.size() < glba_pkg::MAX_JOBS) weights = {weights, weight};
      if (!last) return;
      count = weights.size();
      n = (nodes == 0) ? 1 : ((nodes > glba_pkg::MAX_NODES) ? glba_pkg::MAX_NODES : nodes);
      foreach (loads[i]) loads[i] = 0;
      // stable descending insertion
      for (int i = 0; i < count; i++) begin
         pos = order.size();
         while (pos > 0 && weights[order[pos-1]] < weights[i]) pos--;
         order.insert(pos, i);
      end
      for (int k = 0; k < count; k++) begin
         best = 0;
         for (int i = 1; i < n; i++) if (loads[i] < loads[best]) best = i;
         load = loads[best] + weights[order[k]];
         if (load > 65535) load = 65535;
         loads[best] = load;
         pending_jobs  = {pending_jobs, order[k]};
         pending_nodes = {pending_nodes, best};
         pending_loads = {pending_loads, load};
         pending_last  = {pending_last, bit'(k == count - 1)};
      end
      weights.delete();
   endfunction

   function void check_result(logic [31:0] data, logic last);
      if (pending_jobs.size() == 0) begin
         $error("unexpected result transaction tdata=%h", data);
         errors++;
         return;
      end
      if (data[5:0] != pending_jobs[0]) begin
         $error("job_index expected %0d actual %0d", pending_jobs[0], data[5:0]);
         errors++;
      end
      if (data[9:6] != pending_nodes[0]) begin
         $error("assigned_node expected %0d actual %0d", pending_nodes[0], data[9:6]);
         errors++;
      end
      if (data[25:10] != pending_loads[0]) begin
         $error("node_load_after expected %0d actual %0d", pending_loads[0], data[25:10]);
         errors++;
      end
      if (last != pending_last[0]) begin
         $error("last_result expected %0d actual %0d", pending_last[0], last);
         errors++;
      end
      void'(pending_jobs.pop_front());
      void'(pending_nodes.pop_front());
      void'(pending_loads.pop_front());
      void'(pending_last.pop_front());
   endfunction

   function int outstanding();
      return pending_jobs.size();
   endfunction
endclass

module greedy_load_balance_assigner_top_test;
   import glba_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // job_weight
   logic        req_tlast;   // last_job
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // job_index, assigned_node, node_load_after
   logic        rsp_tlast;   // last_result
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   localparam logic [1:0] NODE_COUNT_ADDR = 2'd0;
   localparam int         CYCLE_LIMIT = 3000000;

   assignment_scoreboard schedule;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_off;
   longint cycles;

   greedy_load_balance_assigner_top u_dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // result side: random stalls, checking on each accepted transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) schedule.check_result(rsp_tdata, rsp_tlast);
      rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // tvalid stays high after a transaction; idle cycles and drain() drop it
   task automatic send_job(logic [9:0] weight, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, weight};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      schedule.note_job(weight, last);
   endtask

   task automatic send_set(int count, int wmode);
      logic [9:0] w;
      for (int i = 0; i < count; i++) begin
         case (wmode)
            0: w = 10'($urandom_range(1023));
            1: w = 10'($urandom_range(3));
            2: w = 10'h3FF;
            default: w = 10'($urandom_range(15) * 64);
         endcase
         send_job(w, i == count - 1);
      end
   endtask

   // let the block drain before touching the register
   task automatic drain();
      req_tvalid <= 1'b0;
      while (schedule.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_nodes(int value);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= NODE_COUNT_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      schedule.set_nodes(value);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_sets(int jobs);
      int sent, n;
      sent = 0;
      while (sent < jobs) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(64) + 1 : $urandom_range(12) + 1;
         send_set(n, $urandom_range(3));
         sent += n;
      end
   endtask

   initial begin
      int node_settings[6] = '{0, 1, 16, 31, 3, 7};
      schedule = new();
      cycles = 0;
      hold_off = 0;
      send_idle_pct = 17; recv_idle_pct = 81;
      reset = 1;
      req_tvalid = 0; req_tdata = 0; req_tlast = 0; rsp_tready = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: single job, extremes, ties, overlong set
      send_job(10'd0, 1);
      send_job(10'h3FF, 1);
      send_set(5, 1);
      drain();
      write_nodes(16);
      send_set(4, 2);
      send_set(20, 0);
      send_set(70, 0);
      drain();

      // long receiver hold-off while the sender keeps going
      hold_off = 1;
      fork
         begin repeat (400) @(posedge clock); hold_off = 0; end
         begin send_set(30, 0); send_set(30, 0); end
      join

      foreach (node_settings[s]) begin
         drain();
         write_nodes(node_settings[s]);
         if (s == 2) begin send_idle_pct = 81; recv_idle_pct = 17; end
         if (s == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
         random_sets(20);
      end

      drain();
      repeat (50) @(posedge clock);
      if (schedule.errors == 0 && schedule.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

### sim.f
+incdir+src
src/glba_pkg.sv
src/glba_ctrl.sv
src/glba_dpath.sv
src/greedy_load_balance_assigner_top.sv
tb/greedy_load_balance_assigner_top_test.sv
